FILE: hdl/bb3_pkg.sv
package bb3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int FW_W       = $clog2(MAX_WIDTH) + 1;
	localparam int FH_W       = $clog2(MAX_HEIGHT) + 1;
	localparam int ROW_W      = FH_W;
	localparam int PIX_W      = 24;
	localparam int CH_W       = 8;
	localparam int CSUM_W     = 10;
	localparam int SUM_W      = 12;
	localparam int WIN_COLS   = 3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = FH_W;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [FW_W-1:0] RESET_WIDTH  = 11'd640;
	localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd480;

	localparam logic [CH_W-1:0] ALPHA = 8'hFF;
	localparam logic [12:0] DIV9_MUL = 13'd7282;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic        action;
		logic [31:0] pixel_in;
	} in_t;

	typedef struct packed {
		logic [31:0] pixel_out;
		logic        frame_end;
	} out_t;

	typedef struct packed {
		pix_t upper;
		pix_t middle;
		pix_t lower;
	} col_t;

	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} entry_t;

	typedef struct packed {
		logic top;
		logic bot;
	} rows_t;

	typedef struct packed {
		logic [CSUM_W-1:0] r;
		logic [CSUM_W-1:0] g;
		logic [CSUM_W-1:0] b;
	} csum_t;

	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
		logic [24:0] p;
		p = 25'(x) * 25'(DIV9_MUL);
		return p[23:16];
	endfunction

endpackage

FILE: hdl/box_blur_3x3_rgba.sv
// 3x3 box blur over a raster-order RGBA8888 pixel stream.
// src channel: one transaction per pixel (action 0) or flush (action 1).
// After the last pixel of a frame, send frame_width + 1 flush transactions
// to push out the final row; a flush sent inside the frame is dropped.
// dst channel: one blurred pixel per transaction, alpha forced to 0xFF,
// frame_end set on the last pixel of the frame. Each result is caused by
// the transaction one line plus one pixel after its source pixel.
// Throughput: one transaction per cycle on both channels while dst is not
// stalled; every stage, the line store port and the window shift advance
// once per cycle that the pipeline is not held. The transaction that causes
// a result passes through the input buffer, line store read, window, sum,
// and divide and output register stages before the result is on dst.
// Config: write frame_width (index 0) or frame_height (index 1) only while
// idle; a write to either restarts the frame. Out-of-range values are
// clamped (width from cfg_data[10:0]). Reset: 640x480, position counters
// zero, pipeline empty. When dst stalls the pipeline holds; a two-entry
// input buffer absorbs src, and src_stall rises once it is full.
module box_blur_3x3_rgba (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  bb3_pkg::in_t                   src_data,
	output logic                           dst_valid,
	input  logic                           dst_stall,
	output bb3_pkg::out_t                  dst_data,
	input  logic                           cfg_wr_en,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef struct packed {
		logic           have;
		logic           frame_end;
		logic           use_c0;
		logic           use_c2;
		bb3_pkg::rows_t rows;
	} ctl_t;

	logic [bb3_pkg::FW_W-1:0]  w_q;
	logic [bb3_pkg::FH_W-1:0]  h_q;
	logic [bb3_pkg::FW_W-1:0]  w_new;
	logic [bb3_pkg::FH_W-1:0]  h_new;
	logic                      cfg_hit;

	bb3_pkg::in_t              fifo_q [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                cnt_q;
	logic                      push;
	logic                      pop;
	bb3_pkg::in_t              head;

	logic                      adv;

	logic [bb3_pkg::COL_W-1:0] ix_q;
	logic [bb3_pkg::ROW_W-1:0] iy_q;
	logic                      in_frame;
	logic                      ignore;
	logic                      take;
	logic                      ix0;
	logic [bb3_pkg::FW_W-1:0]  ix_inc;
	bb3_pkg::pix_t             value_s0;
	ctl_t                      ctl_s0;

	logic                      v_s1;
	bb3_pkg::pix_t             value_s1;
	logic [bb3_pkg::COL_W-1:0] col_s1;
	ctl_t                      ctl_s1;

	bb3_pkg::entry_t           rd_data;
	bb3_pkg::entry_t           wr_data;
	bb3_pkg::col_t             new_col;
	logic                      shift;

	bb3_pkg::col_t             cin  [bb3_pkg::WIN_COLS];
	bb3_pkg::col_t             cout [bb3_pkg::WIN_COLS];
	bb3_pkg::csum_t            csum [bb3_pkg::WIN_COLS];

	logic                      v_s2;
	ctl_t                      ctl_s2;

	logic                      v_s3;
	logic                      fe_s3;
	logic [bb3_pkg::SUM_W-1:0] sr_s3;
	logic [bb3_pkg::SUM_W-1:0] sg_s3;
	logic [bb3_pkg::SUM_W-1:0] sb_s3;

	logic                      dst_valid_q;
	bb3_pkg::out_t             dst_data_q;

	always_comb begin
		w_new = cfg_data[bb3_pkg::FW_W-1:0];
		if (w_new == '0) begin
			w_new = bb3_pkg::FW_W'(1);
		end else if (w_new > bb3_pkg::FW_W'(bb3_pkg::MAX_WIDTH)) begin
			w_new = bb3_pkg::FW_W'(bb3_pkg::MAX_WIDTH);
		end
		h_new = cfg_data[bb3_pkg::FH_W-1:0];
		if (h_new == '0) begin
			h_new = bb3_pkg::FH_W'(1);
		end else if (h_new > bb3_pkg::FH_W'(bb3_pkg::MAX_HEIGHT)) begin
			h_new = bb3_pkg::FH_W'(bb3_pkg::MAX_HEIGHT);
		end
	end

	assign cfg_hit = cfg_wr_en && ((cfg_index == bb3_pkg::CFG_FRAME_WIDTH)
		|| (cfg_index == bb3_pkg::CFG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= bb3_pkg::RESET_WIDTH;
			h_q <= bb3_pkg::RESET_HEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bb3_pkg::CFG_FRAME_WIDTH: begin
					w_q <= w_new;
				end
				bb3_pkg::CFG_FRAME_HEIGHT: begin
					h_q <= h_new;
				end
				default: begin
				end
			endcase
		end
	end

	// input buffer
	assign src_stall = (cnt_q == 2'd2);
	assign push      = src_valid && !src_stall;
	assign adv       = !dst_valid_q || !dst_stall;
	assign pop       = adv && (cnt_q != 2'd0);
	assign head      = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= src_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// frame position and window control
	always_comb begin
		in_frame = iy_q < h_q;
		ignore   = head.action && in_frame;
		take     = pop && !ignore;
		ix0      = (ix_q == '0);
		ix_inc   = {1'b0, ix_q} + bb3_pkg::FW_W'(1);
		value_s0 = in_frame ? head.pixel_in[31:8] : '0;

		ctl_s0.have      = ix0 ? (iy_q >= bb3_pkg::ROW_W'(2)) : (iy_q >= bb3_pkg::ROW_W'(1));
		ctl_s0.rows.top  = ix0 ? (iy_q >= bb3_pkg::ROW_W'(3)) : (iy_q >= bb3_pkg::ROW_W'(2));
		ctl_s0.rows.bot  = ix0 ? ((iy_q - bb3_pkg::ROW_W'(1)) < h_q) : (iy_q < h_q);
		ctl_s0.use_c0    = ix0 ? (w_q >= bb3_pkg::FW_W'(2)) : (ix_q >= bb3_pkg::COL_W'(2));
		ctl_s0.use_c2    = !ix0;
		ctl_s0.frame_end = ix0 && ({1'b0, iy_q} == ({1'b0, h_q} + 14'd1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ix_q <= '0;
			iy_q <= '0;
		end else if (cfg_hit) begin
			ix_q <= '0;
			iy_q <= '0;
		end else if (take) begin
			priority if (ctl_s0.frame_end) begin
				ix_q <= '0;
				iy_q <= '0;
			end else if (ix_inc >= w_q) begin
				ix_q <= '0;
				iy_q <= iy_q + bb3_pkg::ROW_W'(1);
			end else begin
				ix_q <= ix_inc[bb3_pkg::COL_W-1:0];
			end
		end
	end

	// stage 1: line store read, window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && ctl_s2.have;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s1 <= value_s0;
			col_s1   <= ix_q;
			ctl_s1   <= ctl_s0;
			ctl_s2   <= ctl_s1;
		end
	end

	assign wr_data = '{upper: rd_data.middle, middle: value_s1};
	assign new_col = '{upper: rd_data.upper, middle: rd_data.middle, lower: value_s1};
	assign shift   = adv && v_s1;

	bb3_line_store u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rd_addr (ix_q),
		.wr_en   (shift),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// stage 2: window cells
	for (genvar i = 0; i < bb3_pkg::WIN_COLS - 1; i++) begin : g_link
		assign cin[i] = cout[i+1];
	end
	assign cin[bb3_pkg::WIN_COLS-1] = new_col;

	for (genvar i = 0; i < bb3_pkg::WIN_COLS; i++) begin : g_cell
		bb3_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.col_in (cin[i]),
			.rows   (ctl_s2.rows),
			.col    (cout[i]),
			.csum   (csum[i])
		);
	end

	// stage 3: window sums
	always_ff @(posedge clk) begin
		if (adv) begin
			fe_s3 <= ctl_s2.frame_end;
			sr_s3 <= (ctl_s2.use_c0 ? bb3_pkg::SUM_W'(csum[0].r) : '0)
				+ bb3_pkg::SUM_W'(csum[1].r)
				+ (ctl_s2.use_c2 ? bb3_pkg::SUM_W'(csum[2].r) : '0);
			sg_s3 <= (ctl_s2.use_c0 ? bb3_pkg::SUM_W'(csum[0].g) : '0)
				+ bb3_pkg::SUM_W'(csum[1].g)
				+ (ctl_s2.use_c2 ? bb3_pkg::SUM_W'(csum[2].g) : '0);
			sb_s3 <= (ctl_s2.use_c0 ? bb3_pkg::SUM_W'(csum[0].b) : '0)
				+ bb3_pkg::SUM_W'(csum[1].b)
				+ (ctl_s2.use_c2 ? bb3_pkg::SUM_W'(csum[2].b) : '0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (adv) begin
			dst_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dst_data_q.pixel_out <= {bb3_pkg::div9(sr_s3), bb3_pkg::div9(sg_s3),
				bb3_pkg::div9(sb_s3), bb3_pkg::ALPHA};
			dst_data_q.frame_end <= fe_s3;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

`ifndef SYNTHESIS
	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, ix_q} < w_q))
		else $error("column counter past frame width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(iy_q <= (h_q + bb3_pkg::ROW_W'(1))))
		else $error("row counter past flush row");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (dst_data.pixel_out[7:0] == bb3_pkg::ALPHA))
		else $error("output alpha not forced");

	a_buffer_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall) |=> (cnt_q != 2'd0))
		else $error("accepted transaction lost from input buffer");
`endif

endmodule

FILE: hdl/bb3_cell.sv
module bb3_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  bb3_pkg::col_t col_in,
	input  bb3_pkg::rows_t rows,
	output bb3_pkg::col_t col,
	output bb3_pkg::csum_t csum
);

	bb3_pkg::col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col = col_q;

	always_comb begin
		csum.r = (rows.top ? bb3_pkg::CSUM_W'(col_q.upper[23:16]) : '0)
			+ bb3_pkg::CSUM_W'(col_q.middle[23:16])
			+ (rows.bot ? bb3_pkg::CSUM_W'(col_q.lower[23:16]) : '0);
		csum.g = (rows.top ? bb3_pkg::CSUM_W'(col_q.upper[15:8]) : '0)
			+ bb3_pkg::CSUM_W'(col_q.middle[15:8])
			+ (rows.bot ? bb3_pkg::CSUM_W'(col_q.lower[15:8]) : '0);
		csum.b = (rows.top ? bb3_pkg::CSUM_W'(col_q.upper[7:0]) : '0)
			+ bb3_pkg::CSUM_W'(col_q.middle[7:0])
			+ (rows.bot ? bb3_pkg::CSUM_W'(col_q.lower[7:0]) : '0);
	end

endmodule

FILE: hdl/bb3_line_store.sv
module bb3_line_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [bb3_pkg::COL_W-1:0] rd_addr,
	input  logic                      wr_en,
	input  logic [bb3_pkg::COL_W-1:0] wr_addr,
	input  bb3_pkg::entry_t           wr_data,
	output bb3_pkg::entry_t           rd_data
);

	bb3_pkg::entry_t mem [bb3_pkg::MAX_WIDTH];
	bb3_pkg::entry_t rd_q;
	bb3_pkg::entry_t byp_data_q;
	logic            byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

FILE: bench/tb_box_blur_3x3_rgba.sv
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgba;

	localparam logic [bb3_pkg::CFG_IDX_W-1:0] CFG_NONE_2 = 2'd2;
	localparam logic [bb3_pkg::CFG_IDX_W-1:0] CFG_NONE_3 = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 150;
	localparam int MAX_REPORTS = 40;

	logic clk;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	bb3_pkg::in_t src_data = '0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	bb3_pkg::out_t dst_data;
	logic cfg_wr_en = 1'b0;
	logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned frame_w, frame_h;
	int unsigned col_pos, row_pos, out_count;
	bb3_pkg::pix_t upper_line [bb3_pkg::MAX_WIDTH];
	bb3_pkg::pix_t middle_line [bb3_pkg::MAX_WIDTH];
	bb3_pkg::pix_t win [9];
	bb3_pkg::out_t expected_pixels [$];
	bb3_pkg::out_t want_px;

	bit no_gaps = 1'b0;
	int hold_request = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int accepted_items = 0;
	int results_seen = 0;
	int frames_done = 0;
	int reg_writes = 0;
	int stuck = 0;

	box_blur_3x3_rgba dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data(dst_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		out_count = 0;
	endfunction

	function automatic void apply_reg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
			input logic [bb3_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			bb3_pkg::CFG_FRAME_WIDTH: begin
				frame_w = clamp_dim(data[bb3_pkg::FW_W-1:0], bb3_pkg::MAX_WIDTH);
				restart_frame();
			end
			bb3_pkg::CFG_FRAME_HEIGHT: begin
				frame_h = clamp_dim(data, bb3_pkg::MAX_HEIGHT);
				restart_frame();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] box_average(input int cc, input bit use_l,
			input bit use_r, input bit use_t, input bit use_b);
		int acc [3];
		int c, r, ch;
		for (ch = 0; ch < 3; ch++)
			acc[ch] = 0;
		for (c = 0; c < 3; c++) begin
			if (c == cc || (c == cc - 1 && use_l) || (c == cc + 1 && use_r)) begin
				for (r = 0; r < 3; r++) begin
					if ((r != 0 || use_t) && (r != 2 || use_b)) begin
						for (ch = 0; ch < 3; ch++)
							acc[ch] += int'(win[c * 3 + r][(16 - 8 * ch) +: 8]);
					end
				end
			end
		end
		return {8'(acc[0] / 9), 8'(acc[1] / 9), 8'(acc[2] / 9), bb3_pkg::ALPHA};
	endfunction

	function automatic void predict_blur(input bb3_pkg::in_t item, output bit ignored,
			output bit produced, output bb3_pkg::out_t res);
		int unsigned ix, iy, total;
		bit in_frame, have;
		bb3_pkg::pix_t value;
		logic [31:0] px;
		int k;
		ix = col_pos;
		iy = row_pos;
		in_frame = iy < frame_h;
		total = frame_w * frame_h;
		have = 1'b0;
		px = '0;
		res = '0;
		produced = 1'b0;
		ignored = item.action && in_frame;
		if (ignored)
			return;
		value = in_frame ? item.pixel_in[31:8] : '0;
		// emit the last pixel of line iy - 2 at the start of a line
		if (ix == 0 && iy >= 2) begin
			px = box_average(2, frame_w >= 2, 1'b0, iy - 2 >= 1, iy - 1 < frame_h);
			have = 1'b1;
		end
		for (k = 0; k < 6; k++)
			win[k] = win[k + 3];
		win[6] = upper_line[ix];
		win[7] = middle_line[ix];
		win[8] = value;
		upper_line[ix] = middle_line[ix];
		middle_line[ix] = value;
		if (ix >= 1 && iy >= 1) begin
			px = box_average(1, ix >= 2, 1'b1, iy - 1 >= 1, iy < frame_h);
			have = 1'b1;
		end
		ix++;
		if (ix >= frame_w) begin
			ix = 0;
			iy++;
		end
		col_pos = ix;
		row_pos = iy;
		if (!have)
			return;
		produced = 1'b1;
		res.pixel_out = px;
		if (out_count + 1 >= total) begin
			res.frame_end = 1'b1;
			restart_frame();
		end else begin
			res.frame_end = 1'b0;
			out_count++;
		end
	endfunction

	function automatic logic [31:0] random_pixel();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH %s: got %h, want %h (result %0d, t=%0t)",
				what, got, want, results_seen, $time);
	endtask

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected transaction", dst_data.pixel_out, '0);
			end else begin
				want_px = expected_pixels.pop_front();
				if (dst_data.pixel_out !== want_px.pixel_out)
					report_mismatch("pixel_out", dst_data.pixel_out, want_px.pixel_out);
				if (dst_data.frame_end !== want_px.frame_end)
					report_mismatch("frame_end", 32'(dst_data.frame_end),
						32'(want_px.frame_end));
				if (want_px.frame_end)
					frames_done++;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (hold_request != hold_taken) begin
			hold_taken <= hold_request;
			hold_left <= HOLD_CYCLES;
			dst_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dst_stall <= 1'b1;
		end else begin
			dst_stall <= !no_gaps && ($urandom_range(0, 99) < 17);
		end
	end

	initial begin
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || cfg_wr_en)
				stuck = 0;
			else
				stuck++;
		end
		$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, expected_pixels.size());
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(input logic action, input logic [31:0] pixel);
		bb3_pkg::in_t item;
		bit ignored, produced;
		bb3_pkg::out_t res;
		item.action = action;
		item.pixel_in = pixel;
		while (!no_gaps && $urandom_range(0, 99) < 17) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= item;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		predict_blur(item, ignored, produced, res);
		if (produced)
			expected_pixels.push_back(res);
		if (!ignored)
			accepted_items++;
	endtask

	task automatic wait_idle();
		src_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
			input logic [bb3_pkg::CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		apply_reg(idx, data);
		reg_writes++;
	endtask

	task automatic set_frame(input int w, input int h);
		write_reg(bb3_pkg::CFG_FRAME_WIDTH, bb3_pkg::CFG_DATA_W'(w));
		write_reg(bb3_pkg::CFG_FRAME_HEIGHT, bb3_pkg::CFG_DATA_W'(h));
	endtask

	// pixel_limit < 0 sends the whole frame and its flush tail
	task automatic send_frame(input int pixel_limit, input int pause_at, input bit noisy);
		int total, i;
		total = frame_w * frame_h;
		for (i = 0; i < total; i++) begin
			if (i == pixel_limit)
				return;
			if (i == pause_at)
				write_reg($urandom_range(0, 1) ? CFG_NONE_2 : CFG_NONE_3,
					bb3_pkg::CFG_DATA_W'($urandom));
			if (noisy && $urandom_range(0, 99) < 8)
				send_item(1'b1, $urandom);
			send_item(1'b0, random_pixel());
		end
		for (i = 0; i <= frame_w; i++)
			send_item($urandom_range(0, 99) >= 20, $urandom);
	endtask

	task automatic test_reset_size();
		int i;
		for (i = 0; i < bb3_pkg::RESET_WIDTH + 3; i++)
			send_item(1'b0, random_pixel());
	endtask

	task automatic test_edge_pixels();
		logic [31:0] pattern [9];
		int i;
		pattern = '{32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h0000_00FF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_0000, 32'h8080_8080, 32'h7F7F_7F7F};
		set_frame(3, 3);
		send_item(1'b1, 32'hFFFF_FFFF);
		for (i = 0; i < 9; i++)
			send_item(1'b0, pattern[i]);
		send_item(1'b0, 32'hA5C3_3C5A);
		for (i = 0; i < 3; i++)
			send_item(1'b1, 32'h0000_0000);
	endtask

	task automatic test_register_limits();
		write_reg(bb3_pkg::CFG_FRAME_WIDTH, '0);
		write_reg(bb3_pkg::CFG_FRAME_HEIGHT, '0);
		send_frame(-1, -1, 1'b0);
		write_reg(bb3_pkg::CFG_FRAME_WIDTH, 13'h1802);
		write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 13'd2);
		send_frame(-1, 2, 1'b1);
	endtask

	task automatic test_max_sizes();
		write_reg(bb3_pkg::CFG_FRAME_WIDTH, 13'h07FF);
		write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
		no_gaps = 1'b1;
		send_frame(bb3_pkg::MAX_WIDTH + 3, -1, 1'b0);
		no_gaps = 1'b0;
		write_reg(bb3_pkg::CFG_FRAME_WIDTH, 13'd1);
		write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 13'd4096);
		send_frame(40, -1, 1'b0);
	endtask

	task automatic test_backpressure();
		set_frame(8, 5);
		hold_request++;
		send_frame(-1, -1, 1'b0);
	endtask

	task automatic test_drain_pause();
		set_frame(6, 5);
		send_frame(-1, 17, 1'b1);
	endtask

	task automatic test_random_frames();
		int start, w, h, reps, k, limit, pause_at;
		bit noisy;
		start = accepted_items;
		while (accepted_items - start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0: w = $urandom_range(25, 40);
				1, 2, 3, 4: w = $urandom_range(7, 24);
				default: w = $urandom_range(1, 6);
			endcase
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			write_reg(bb3_pkg::CFG_FRAME_WIDTH, {2'($urandom), 11'(w)});
			write_reg(bb3_pkg::CFG_FRAME_HEIGHT, bb3_pkg::CFG_DATA_W'(h));
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? CFG_NONE_2 : CFG_NONE_3,
					bb3_pkg::CFG_DATA_W'($urandom));
			reps = $urandom_range(1, 3);
			for (k = 0; k < reps; k++) begin
				limit = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w * h - 1) : -1;
				pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, w * h - 1) : -1;
				noisy = $urandom_range(0, 3) == 0;
				send_frame(limit, pause_at, noisy);
				if (limit >= 0)
					break;
			end
		end
	endtask

	initial begin
		frame_w = bb3_pkg::RESET_WIDTH;
		frame_h = bb3_pkg::RESET_HEIGHT;
		for (int i = 0; i < bb3_pkg::MAX_WIDTH; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			win[i] = '0;
		restart_frame();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_edge_pixels();
		test_register_limits();
		test_max_sizes();
		test_backpressure();
		test_drain_pause();
		test_random_frames();

		wait_idle();
		repeat (12) @(posedge clk);
		$display("Covered %0d source transactions and %0d register writes,",
			accepted_items, reg_writes);
		$display("  %0d blurred pixels compared, %0d complete frames, %0d mismatches.",
			results_seen, frames_done, mismatch_count);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
